// ----- hdl/pcbp_pkg.sv -----
// Shared types and constants for the prefix code bit packer.
// Used by pcbp_ctrl, pcbp_dp and prefix_code_bit_packer; depends on nothing.
`default_nettype none

package pcbp_pkg;

    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;
    localparam int PCNT_W = 3;
    localparam int ACC_W  = WORD_W + PEND_W;
    localparam int CNT_W  = 16;

    typedef struct packed {
        logic load;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic has_byte;
        logic want_out;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- hdl/prefix_code_bit_packer.sv -----
// Channel       | direction | handshake          | payload
// request in    | input     | i_valid / o_ready  | i_code_word, i_end_of_block
// result out    | output    | o_valid / i_ready  | o_packed_byte, o_byte_valid,
//               |           |                    | o_final_result, o_bytes_so_far
// A request takes a load step, one emit step per full byte and a closing step;
// the result register passes one byte per cycle while the output is not stalled.
// A stalled result holds the byte loop and a block's closing result; intake waits.
// Reset is synchronous and active low and clears pending bits and the byte count.
// Top level of the prefix code bit packer; depends on pcbp_pkg, pcbp_ctrl and pcbp_dp.
`default_nettype none

module prefix_code_bit_packer
    import pcbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [WORD_W-1:0] i_code_word,
    input  wire logic              i_end_of_block,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [BYTE_W-1:0]      o_packed_byte,
    output logic                   o_byte_valid,
    output logic                   o_final_result,
    output logic [CNT_W-1:0]       o_bytes_so_far
);

    t_cmd    cmd;
    t_status status;

    pcbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pcbp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_code_word    (i_code_word),
        .i_end_of_block (i_end_of_block),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_packed_byte  (o_packed_byte),
        .o_byte_valid   (o_byte_valid),
        .o_final_result (o_final_result),
        .o_bytes_so_far (o_bytes_so_far)
    );

endmodule

`default_nettype wire

// ----- hdl/pcbp_ctrl.sv -----
// Sequencing state machine of the prefix code bit packer.
// Depends on pcbp_pkg; drives the datapath in pcbp_dp by command and status.
`default_nettype none

module pcbp_ctrl
    import pcbp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ready = r_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EMIT;
                    n_ready    = 1'b0;
                end
            end
            S_EMIT: begin
                if (i_status.has_byte) begin
                    o_cmd.emit = i_status.out_free;
                end else if (!i_status.want_out || i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    n_ready      = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready;

endmodule

`default_nettype wire

// ----- hdl/pcbp_dp.sv -----
// Datapath of the prefix code bit packer: bit accumulator, pending bits,
// byte counter and output register. Depends on pcbp_pkg; commanded by pcbp_ctrl.
`default_nettype none

module pcbp_dp
    import pcbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic [WORD_W-1:0] i_code_word,
    input  wire logic              i_end_of_block,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [BYTE_W-1:0]      o_packed_byte,
    output logic                   o_byte_valid,
    output logic                   o_final_result,
    output logic [CNT_W-1:0]       o_bytes_so_far
);

    logic [ACC_W-1:0]  r_acc;
    logic              r_last;
    logic              r_any;
    logic [PEND_W-1:0] r_pend_bits;
    logic [PCNT_W-1:0] r_pend_cnt;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_obval;
    logic              r_ofin;
    logic [CNT_W-1:0]  r_ocnt;

    logic [CNT_W-1:0]  n_bump;
    logic [PCNT_W-1:0] n_pend_cnt;
    logic [ACC_W-1:0]  n_load;
    logic              acc_nonzero;

    assign acc_nonzero = |r_acc;
    assign n_bump      = (r_count == {CNT_W{1'b1}}) ? r_count : r_count + CNT_W'(1);
    assign n_load      = {{WORD_W{1'b0}}, r_pend_bits}
                       | ({{PEND_W{1'b0}}, i_code_word} << r_pend_cnt);

    // The pending bit count is taken from the highest set residual bit, which is taken as the top bit of the last word.
    always_comb begin
        n_pend_cnt = '0;
        for (int k = 0; k < PEND_W; k++) begin
            if (r_acc[k]) begin
                n_pend_cnt = PCNT_W'(k + 1);
            end
        end
    end

    assign o_status.has_byte = |r_acc[ACC_W-1:BYTE_W-1];
    assign o_status.want_out = r_last && (acc_nonzero || !r_any);
    assign o_status.out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_count     <= '0;
            r_any       <= 1'b0;
            r_last      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_last <= i_end_of_block;
                r_any  <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_count  <= n_bump;
                r_any    <= 1'b1;
                r_ovalid <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_pend_bits <= '0;
                    r_pend_cnt  <= '0;
                    r_count     <= '0;
                    if (o_status.want_out) begin
                        r_ovalid <= 1'b1;
                    end
                end else begin
                    r_pend_bits <= r_acc[PEND_W-1:0];
                    r_pend_cnt  <= n_pend_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= n_load;
        end else if (i_cmd.emit) begin
            r_acc <= r_acc >> BYTE_W;
        end
        if (i_cmd.emit) begin
            r_obyte <= r_acc[BYTE_W-1:0];
            r_obval <= 1'b1;
            r_ofin  <= r_last && !(|r_acc[ACC_W-1:BYTE_W]);
            r_ocnt  <= n_bump;
        end else if (i_cmd.finish && o_status.want_out) begin
            r_ofin <= 1'b1;
            if (acc_nonzero) begin
                r_obyte <= r_acc[BYTE_W-1:0];
                r_obval <= 1'b1;
                r_ocnt  <= n_bump;
            end else begin
                r_obyte <= '0;
                r_obval <= 1'b0;
                r_ocnt  <= r_count;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_packed_byte  = r_obyte;
    assign o_byte_valid   = r_obval;
    assign o_final_result = r_ofin;
    assign o_bytes_so_far = r_ocnt;

`ifndef ASSERT_OFF
    a_pend_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_cnt == '0) == (r_pend_bits == '0))
        else $error("pending bit count disagrees with pending bits");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || (i_cmd.finish && o_status.want_out)) |-> o_status.out_free)
        else $error("result written while the output register is still occupied");

    a_block_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_last) |=> (r_count == '0 && r_pend_cnt == '0))
        else $error("state not cleared at the end of a block");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({i_cmd.load, i_cmd.emit, i_cmd.finish}) <= 1)
        else $error("more than one datapath command in one cycle");
`endif

endmodule

`default_nettype wire
